>>> sv/pss_pkg.sv
// Shared types and constants for the plucked-string synthesiser.
`default_nettype none
package pss_pkg;

  localparam int MAX_PERIOD = 4096;
  localparam int RING_AW    = $clog2(MAX_PERIOD);
  localparam int PER_W      = RING_AW + 1;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 17;
  localparam int SEED_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int SUM_W      = SMP_W + 1;
  localparam int PROD_W     = SUM_W + GAIN_W + 1;
  localparam int FRAC_SH    = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 17'd65274;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
  localparam logic [SEED_W-1:0] SEED_RST  = 16'd44257;
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic signed [SMP_W-1:0] FULL_POS = 16'sd32767;
  localparam logic signed [SMP_W-1:0] FULL_NEG = -16'sd32767;

  localparam logic [PER_W-1:0] PER_MIN = PER_W'(2);
  localparam logic [PER_W-1:0] PER_MAX = PER_W'(MAX_PERIOD);

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_PLUCK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_WRITE,
    S_FILL
  } state_t;

  typedef struct packed {
    logic take_tick;
    logic take_pluck;
    logic sel_next;
    logic cap_a;
    logic mul;
    logic commit;
    logic fill_wr;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/pss_if.sv
// Valid/ready channel interfaces for pluck/tick items and output samples.
`default_nettype none
interface pss_in_if;
  import pss_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [PER_W-1:0] period_len;
  modport src (output valid, output func, output period_len, input ready);
  modport snk (input valid, input func, input period_len, output ready);
endinterface

interface pss_out_if;
  import pss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  modport src (output valid, output sample, input ready);
  modport snk (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> sv/plucked_string_synth_unit.sv
// Top level of the Karplus-Strong plucked-string synthesiser.
// Input channel in_if carries func (0 tick, 1 pluck) and period_len.
// Output channel out_if carries one Q1.15 sample per tick; a pluck gives none.
// cfg_we/cfg_idx/cfg_wdata write decay_gain (index 0) or noise_seed (index 1);
// writing the seed reloads the noise LFSR. Write only while the block is idle.
// A tick passes READ_A, READ_B and WRITE after acceptance before the sample beat appears: two
// reads and one write of the single-port-read delay ring, plus the multiply.
// A tick before any pluck skips the ring, goes straight to WRITE and presents 0.
// A pluck writes P noise samples in FILL, P the clamped period (2..4096): one ring
// write per cycle while the LFSR steps.
// in_if.ready is high only while the sequencer is idle; the output register
// lets a new item be taken while an earlier sample still waits. If the
// receiver stalls, a finished tick holds before its ring write until the
// output register frees up.
// Reset (rst_n low, synchronous) clears the note, head and output valid and
// restores the register defaults; the delay ring is not cleared.
`default_nettype none
module plucked_string_synth_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  pss_in_if.snk                               in_if,
  pss_out_if.src                              out_if,
  input  wire logic                           cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pss_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_period_len (in_if.period_len),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_pcm       (out_if.sample)
  );
endmodule
`default_nettype wire

>>> sv/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/pss_ctrl.sv
// Sequencer for tick and pluck operations.
`default_nettype none
module pss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_func,
  output logic               in_ready,
  input  wire pss_pkg::sts_t sts,
  output pss_pkg::cmd_t      cmd
);
  import pss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_PLUCK) begin
            state_nxt = S_FILL;
          end else if (sts.active) begin
            state_nxt = S_READ_A;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_READ_A: state_nxt = S_READ_B;
      S_READ_B: state_nxt = S_WRITE;
      S_WRITE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (sts.fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.take_pluck = in_valid && (in_func == FUNC_PLUCK);
        cmd.take_tick  = in_valid && (in_func == FUNC_TICK);
      end
      S_READ_A: begin
        cmd.sel_next = 1'b1;
        cmd.cap_a    = 1'b1;
      end
      S_READ_B: cmd.mul = 1'b1;
      S_WRITE:  cmd.commit = sts.out_free;
      S_FILL:   cmd.fill_wr = 1'b1;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire

>>> sv/pss_dp.sv
// Datapath: delay ring, LFSR noise, decay filter and output register.
`default_nettype none
module pss_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [pss_pkg::PER_W-1:0]      in_period_len,
  input  wire pss_pkg::cmd_t                  cmd,
  output pss_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [pss_pkg::SMP_W-1:0]    out_pcm
);
  import pss_pkg::*;

  logic [GAIN_W-1:0]         gain_r;
  logic [SEED_W-1:0]         lfsr_r, lfsr_nxt;
  logic [RING_AW-1:0]        head_r, head_nxt;
  logic [PER_W-1:0]          period_r, period_nxt;
  logic                      active_r;
  logic                      zero_r;
  logic [RING_AW-1:0]        fill_r;
  logic signed [SMP_W-1:0]   a_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      out_valid_r;
  logic signed [SMP_W-1:0]   sample_r;

  logic [SEED_W-1:0]         seed_in;
  logic [GAIN_W-1:0]         gain_eff;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PROD_W-FRAC_SH-1:0] shifted;
  logic signed [SMP_W-1:0]   sat_v;
  logic signed [SMP_W-1:0]   noise_v;
  logic [PER_W-1:0]          head_inc;
  logic                      ram_we;
  logic [RING_AW-1:0]        ram_waddr, ram_raddr;
  logic [SMP_W-1:0]          ram_wdata, ram_rdata;

  assign seed_in  = (cfg_wdata[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_wdata[SEED_W-1:0];
  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign noise_v  = lfsr_r[0] ? FULL_POS : FULL_NEG;

  always_comb begin
    period_nxt = in_period_len;
    if (in_period_len < PER_MIN) begin
      period_nxt = PER_MIN;
    end else if (in_period_len > PER_MAX) begin
      period_nxt = PER_MAX;
    end
  end

  assign head_inc = {1'b0, head_r} + PER_W'(1);
  assign head_nxt = (head_inc >= period_r) ? '0 : head_inc[RING_AW-1:0];

  assign gain_eff = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;
  assign sum      = SUM_W'(a_r) + SUM_W'($signed(ram_rdata));
  assign shifted  = prod_r[PROD_W-1:FRAC_SH];

  always_comb begin
    sat_v = shifted[SMP_W-1:0];
    if (shifted > $signed((PROD_W-FRAC_SH)'(FULL_POS))) begin
      sat_v = FULL_POS;
    end else if (shifted < $signed((PROD_W-FRAC_SH)'(FULL_NEG))) begin
      sat_v = FULL_NEG;
    end
  end

  assign ram_we    = cmd.fill_wr || (cmd.commit && !zero_r);
  assign ram_waddr = cmd.fill_wr ? fill_r : head_r;
  assign ram_wdata = cmd.fill_wr ? noise_v : sat_v;
  assign ram_raddr = cmd.sel_next ? head_nxt : head_r;

  pss_ram #(.WIDTH(SMP_W), .DEPTH(MAX_PERIOD)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RST;
      lfsr_r      <= SEED_RST;
      head_r      <= '0;
      period_r    <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_DECAY_GAIN) begin
        gain_r <= cfg_wdata[GAIN_W-1:0];
      end
      if (cfg_we && cfg_idx == CFG_NOISE_SEED) begin
        lfsr_r <= seed_in;
      end else if (cmd.fill_wr) begin
        lfsr_r <= lfsr_nxt;
      end
      if (cmd.take_pluck) begin
        period_r <= period_nxt;
        head_r   <= '0;
        active_r <= 1'b1;
      end else if (cmd.commit && !zero_r) begin
        head_r <= head_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_tick) begin
      zero_r <= !active_r;
    end
    if (cmd.take_pluck) begin
      fill_r <= '0;
    end else if (cmd.fill_wr) begin
      fill_r <= fill_r + RING_AW'(1);
    end
    if (cmd.cap_a) begin
      a_r <= $signed(ram_rdata);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum) * PROD_W'($signed({1'b0, gain_eff}));
    end
    if (cmd.commit) begin
      sample_r <= zero_r ? '0 : sat_v;
    end
  end

  assign sts.active    = active_r;
  assign sts.fill_last = ({1'b0, fill_r} == period_r - PER_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_pcm   = sample_r;
endmodule
`default_nettype wire

>>> sv/pss_checker.sv
// Port-level checker for the plucked-string synthesiser, with its bind.
`default_nettype none
module pss_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic signed [pss_pkg::SMP_W-1:0] out_pcm
);
  import pss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pcm))
    else $error("output sample changed while stalled");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pcm != -16'sd32768)
    else $error("sample outside saturation range");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");
endmodule

bind plucked_string_synth_unit pss_checker u_pss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_pcm   (out_if.sample)
);
`default_nettype wire

>>> verif/pss_checker.sv
// Sample predictor and scoreboard for the plucked-string synthesiser channels.
`default_nettype none
module pss_tb_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic                             in_func,
  input  wire logic [pss_pkg::PER_W-1:0]        in_period,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic signed [pss_pkg::SMP_W-1:0] out_pcm,
  input  wire logic                             cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                    err_count,
  output int                                    samples_due
);
  import pss_pkg::*;

  localparam int DUE_DEPTH = 16;

  logic signed [SMP_W-1:0] ring [MAX_PERIOD];
  logic [RING_AW-1:0]      head;
  logic [PER_W-1:0]        note_len;
  logic                    sounding;
  logic [SEED_W-1:0]       lfsr;
  logic [GAIN_W-1:0]       gain;
  logic signed [SMP_W-1:0] due_buf [DUE_DEPTH];
  int                      due_wr;
  int                      due_rd;
  int                      errs;

  task automatic pluck_string(input logic [PER_W-1:0] req);
    int  len;
    logic lsb;
    len = (req < PER_MIN) ? int'(PER_MIN) : (req > PER_MAX) ? int'(PER_MAX) : int'(req);
    for (int i = 0; i < len; i++) begin
      lsb  = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) begin
        lfsr = lfsr ^ LFSR_TAPS;
      end
      ring[i] = lsb ? FULL_POS : FULL_NEG;
    end
    note_len = PER_W'(len);
    head     = '0;
    sounding = 1'b1;
  endtask

  task automatic next_sample(output logic signed [SMP_W-1:0] smp);
    int     h;
    int     nx;
    longint g;
    longint acc;
    if (!sounding) begin
      smp = '0;
    end else begin
      h = int'(head);
      if (h >= int'(note_len)) begin
        h = 0;
      end
      nx = h + 1;
      if (nx >= int'(note_len)) begin
        nx = 0;
      end
      g   = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
      acc = (longint'(ring[h]) + longint'(ring[nx])) * g;
      acc = acc >>> FRAC_SH;
      if (acc > longint'(FULL_POS)) begin
        acc = longint'(FULL_POS);
      end
      if (acc < longint'(FULL_NEG)) begin
        acc = longint'(FULL_NEG);
      end
      smp     = SMP_W'(acc);
      ring[h] = smp;
      head    = RING_AW'(nx);
    end
  endtask

  always @(posedge clk) begin
    logic signed [SMP_W-1:0] want;
    logic [SEED_W-1:0]       s;
    if (!rst_n) begin
      head     = '0;
      note_len = '0;
      sounding = 1'b0;
      gain     = GAIN_RST;
      lfsr     = SEED_RST;
      errs     = 0;
      due_wr   = 0;
      due_rd   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_wr == due_rd) begin
          errs++;
          $display("%0t: sample beat with none expected: expected none, got %0d",
                   $time, out_pcm);
        end else begin
          want = due_buf[due_rd % DUE_DEPTH];
          due_rd++;
          if (out_pcm !== want) begin
            errs++;
            $display("%0t: sample mismatch: expected %0d, got %0d", $time, want, out_pcm);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_DECAY_GAIN) begin
          gain = cfg_wdata[GAIN_W-1:0];
        end else if (cfg_idx == CFG_NOISE_SEED) begin
          s    = cfg_wdata[SEED_W-1:0];
          lfsr = (s == '0) ? SEED_W'(1) : s;
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_PLUCK) begin
          pluck_string(in_period);
        end else begin
          next_sample(want);
          due_buf[due_wr % DUE_DEPTH] = want;
          due_wr++;
        end
      end
    end
    err_count   <= errs;
    samples_due <= due_wr - due_rd;
  end

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Top-level bench: clock, reset, pluck/tick stimulus, register phases and verdict.
`default_nettype none
module testbench;
  import pss_pkg::*;

  localparam int RUN_LIMIT = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    err_count;
  int                    samples_due;
  int                    cycles;
  int                    items_done;
  int                    plucks_done;
  logic                  calm;

  pss_in_if  in_ch ();
  pss_out_if out_ch ();

  plucked_string_synth_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pss_tb_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_func     (in_ch.func),
    .in_period   (in_ch.period_len),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_pcm     (out_ch.sample),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .err_count   (err_count),
    .samples_due (samples_due)
  );

  // no idling on either side through this window
  assign calm = (items_done >= 1000) && (items_done < 1300);

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result sink: random stalls plus one long hold-off to back the block up
  initial begin
    int hold;
    bit held_once;
    hold      = 0;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_once && items_done >= 600) begin
        held_once = 1'b1;
        hold      = 400;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
      @(posedge clk);
    end
  end

  task automatic send_item(input logic f, input logic [PER_W-1:0] len);
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.period_len <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_done++;
    if (f == FUNC_PLUCK) begin
      plucks_done++;
    end
  endtask

  // drain samples, then let a longest pluck fill finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (MAX_PERIOD + 16) @(posedge clk);
  endtask

  task automatic write_regs(input logic [GAIN_W-1:0] g, input logic [CFG_DATA_W-1:0] s);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DECAY_GAIN;
    cfg_wdata <= CFG_DATA_W'(g);
    @(posedge clk);
    cfg_idx   <= CFG_NOISE_SEED;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly ticks on a live note; plucks mostly short, a few long or out of range
  task automatic random_phase(input int n_items);
    int               r;
    logic [PER_W-1:0] len;
    send_item(FUNC_PLUCK, PER_W'($urandom_range(64, 2)));
    for (int i = 1; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        r = $urandom_range(199);
        if (r == 0) begin
          len = PER_W'($urandom_range(8191, 4097));
        end else if (r < 5) begin
          len = (r == 4) ? PER_MAX : PER_W'($urandom_range(1));
        end else if (r < 25) begin
          len = PER_W'($urandom_range(MAX_PERIOD, 65));
        end else begin
          len = PER_W'($urandom_range(64, 2));
        end
        send_item(FUNC_PLUCK, len);
      end else begin
        send_item(FUNC_TICK, PER_W'($urandom));
      end
    end
  endtask

  initial begin
    items_done  = 0;
    plucks_done = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_TICK;
    in_ch.period_len <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_DECAY_GAIN;
    cfg_wdata        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // silent string, then clamped and odd periods at reset settings
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, PER_W'(8191));
    send_item(FUNC_PLUCK, '0);
    repeat (4) send_item(FUNC_TICK, PER_W'($urandom));
    send_item(FUNC_PLUCK, PER_W'(1));
    send_item(FUNC_TICK, '0);
    send_item(FUNC_PLUCK, PER_W'(4097));
    repeat (2) send_item(FUNC_TICK, '0);
    send_item(FUNC_PLUCK, PER_W'(8191));
    send_item(FUNC_TICK, PER_W'(8191));
    send_item(FUNC_PLUCK, PER_W'(3));
    repeat (3) send_item(FUNC_TICK, '0);

    settle();
    write_regs(GAIN_ONE, '0);
    random_phase(390);
    settle();
    write_regs('0, CFG_DATA_W'(17'h1FFFF));
    random_phase(390);
    settle();
    write_regs(GAIN_W'(17'h1FFFF), CFG_DATA_W'($urandom));
    random_phase(390);
    settle();
    write_regs(GAIN_W'($urandom_range(65536, 60000)), CFG_DATA_W'(1));
    random_phase(390);
    settle();
    write_regs(GAIN_W'($urandom_range(65536)), CFG_DATA_W'($urandom_range(65535, 1)));
    random_phase(390);
    settle();

    $display("Covered %0d beats (%0d plucks, %0d ticks) over six gain/seed settings,",
             items_done, plucks_done, items_done - plucks_done);
    $display("periods 0..8191 requested, gains 0..131071, seeds including zero.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
sv/pss_pkg.sv
sv/pss_if.sv
sv/pss_ram.sv
sv/pss_ctrl.sv
sv/pss_dp.sv
sv/plucked_string_synth_unit.sv
sv/pss_checker.sv
verif/pss_checker.sv
verif/testbench.sv
